// ----- rtl/core/ppdm_pkg.sv -----
package ppdm_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int TIMER_WRAP_W = 17;
  localparam int RATE_W       = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [TIMER_WRAP_W-1:0] TIMER_WRAP_RESET = 17'd50000;
  localparam logic [RATE_W-1:0]       REF_RATE_RESET   = 32'd16000000;
  localparam logic [TIMER_WRAP_W-1:0] DUTY_SCALE       = 17'd10000;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_WRAP = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REF_RATE   = 1'd1;

  // Request opcodes.
  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_WRAP = 2'd1;
  localparam logic [1:0] OP_EDGE = 2'd2;

  // Divider geometry: the duty dividend is at most 46 bits wide.
  localparam int DIVIDEND_W = 48;
  localparam int STEP_CNT_W = 6;
  localparam logic [STEP_CNT_W-1:0] FREQ_LAST_STEP = 6'd31;
  localparam logic [STEP_CNT_W-1:0] DUTY_LAST_STEP = 6'd47;

  localparam int PROD_W = 49;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_PER,
    ST_MUL_HIGH,
    ST_SUM_HIGH,
    ST_MUL_DUTY,
    ST_DIV_FREQ,
    ST_LOAD_DUTY,
    ST_DIV_DUTY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        edge_rising;
    logic [15:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] period_ticks;
    logic [31:0] high_ticks;
    logic [31:0] freq_hz;
    logic [31:0] duty_hundredths;
    logic        zero_period;
  } out_item_t;

endpackage

// ----- rtl/core/pulse_period_duty_meter.sv -----
// Arm, wrap and non-final edge requests leave the meter idle, ready for the next request.
// The final rising edge starts a measurement: the sequencer runs the multiplies and sums,
// then the two divisions (skipped when the period is zero); out_valid rises as it leaves ST_DONE,
// later while the previous result is stalled. No request is taken meanwhile. The shared
// restoring divider makes one quotient bit per cycle: 32 steps for the frequency, then 48 for the duty.
// Synchronous active-low reset disarms the meter, clears the overflow count and drops out_valid.
module pulse_period_duty_meter #(
  parameter int COUNT_WIDTH = ppdm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  ppdm_pkg::in_item_t                 in_data,

  output logic                               out_valid,
  input  logic                               out_stall,
  output ppdm_pkg::out_item_t                out_data,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppdm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppdm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DW = ppdm_pkg::DIVIDEND_W;

  ppdm_pkg::state_t state_r, state_nxt;
  ppdm_pkg::phase_t phase_r;
  logic             armed_r;

  logic [ppdm_pkg::TIMER_WRAP_W-1:0] timer_wrap_r;
  logic [ppdm_pkg::RATE_W-1:0]       ref_rate_r;

  logic [COUNT_WIDTH-1:0] overflow_r;
  logic [COUNT_WIDTH-1:0] stamp1_r;
  logic [COUNT_WIDTH-1:0] stamp2_r;
  logic [15:0]            cap1_r;
  logic [15:0]            cap2_r;
  logic [15:0]            cap3_r;

  logic [31:0] dper_r;
  logic [31:0] dhigh_r;
  logic [31:0] period_r;
  logic [31:0] high_r;
  logic [31:0] freq_r;

  logic [ppdm_pkg::PROD_W-1:0]     prod_r;
  logic [31:0]                     rem_r;
  logic [DW-1:0]                   quo_r;
  logic [ppdm_pkg::STEP_CNT_W-1:0] cnt_r;

  logic      out_valid_r;
  ppdm_pkg::out_item_t out_data_r;

  logic accept;
  logic take_first;
  logic take_second;
  logic start_meas;
  logic out_free;

  logic [COUNT_WIDTH-1:0] dper_cw;
  logic [COUNT_WIDTH-1:0] dhigh_cw;
  logic [63:0]            dper_ext;
  logic [63:0]            dhigh_ext;

  logic [31:0]                       mul_a;
  logic [ppdm_pkg::TIMER_WRAP_W-1:0] mul_b;
  logic [ppdm_pkg::PROD_W-1:0]       mul_p;

  logic [32:0] div_shift;
  logic [33:0] div_trial;
  logic [31:0] rem_step;
  logic [DW-1:0] quo_step;

  logic [31:0] duty_sat;
  logic        period_zero;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Edge sequencing. Phase value 3 never occurs and falls under the first-rise arm.
  always_comb begin
    take_first  = 1'b0;
    take_second = 1'b0;
    start_meas  = 1'b0;
    if (accept && in_data.op == ppdm_pkg::OP_EDGE && armed_r) begin
      case (phase_r)
        ppdm_pkg::PH_FALL:  take_second = !in_data.edge_rising;
        ppdm_pkg::PH_RISE2: start_meas  = in_data.edge_rising;
        default:            take_first  = in_data.edge_rising;
      endcase
    end
  end

  assign dper_cw   = overflow_r - stamp1_r;
  assign dhigh_cw  = stamp2_r - stamp1_r;
  assign dper_ext  = 64'(dper_cw);
  assign dhigh_ext = 64'(dhigh_cw);

  // Shared multiplier.
  always_comb begin
    unique case (state_r)
      ppdm_pkg::ST_MUL_PER: begin
        mul_a = dper_r;
        mul_b = timer_wrap_r;
      end
      ppdm_pkg::ST_MUL_HIGH: begin
        mul_a = dhigh_r;
        mul_b = timer_wrap_r;
      end
      default: begin
        mul_a = high_r;
        mul_b = ppdm_pkg::DUTY_SCALE;
      end
    endcase
  end

  assign mul_p = ppdm_pkg::PROD_W'(mul_a) * ppdm_pkg::PROD_W'(mul_b);

  // Restoring divider step; the remainder always stays below the period.
  assign div_shift = {rem_r, quo_r[DW-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, period_r};
  assign rem_step  = div_trial[33] ? div_shift[31:0] : div_trial[31:0];
  assign quo_step  = {quo_r[DW-2:0], !div_trial[33]};

  assign duty_sat    = (quo_r[DW-1:32] != '0) ? 32'hFFFF_FFFF : quo_r[31:0];
  assign period_zero = (period_r == 32'd0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppdm_pkg::ST_IDLE:      if (start_meas) state_nxt = ppdm_pkg::ST_MUL_PER;
      ppdm_pkg::ST_MUL_PER:   state_nxt = ppdm_pkg::ST_MUL_HIGH;
      ppdm_pkg::ST_MUL_HIGH:  state_nxt = ppdm_pkg::ST_SUM_HIGH;
      ppdm_pkg::ST_SUM_HIGH:  state_nxt = ppdm_pkg::ST_MUL_DUTY;
      ppdm_pkg::ST_MUL_DUTY: begin
        state_nxt = period_zero ? ppdm_pkg::ST_DONE : ppdm_pkg::ST_DIV_FREQ;
      end
      ppdm_pkg::ST_DIV_FREQ: begin
        if (cnt_r == ppdm_pkg::FREQ_LAST_STEP) state_nxt = ppdm_pkg::ST_LOAD_DUTY;
      end
      ppdm_pkg::ST_LOAD_DUTY: state_nxt = ppdm_pkg::ST_DIV_DUTY;
      ppdm_pkg::ST_DIV_DUTY: begin
        if (cnt_r == ppdm_pkg::DUTY_LAST_STEP) state_nxt = ppdm_pkg::ST_DONE;
      end
      ppdm_pkg::ST_DONE:      if (out_free) state_nxt = ppdm_pkg::ST_IDLE;
      default:                state_nxt = ppdm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = (state_r != ppdm_pkg::ST_IDLE);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppdm_pkg::ST_IDLE;
      armed_r      <= 1'b0;
      phase_r      <= ppdm_pkg::PH_RISE1;
      overflow_r   <= '0;
      out_valid_r  <= 1'b0;
      timer_wrap_r <= ppdm_pkg::TIMER_WRAP_RESET;
      ref_rate_r   <= ppdm_pkg::REF_RATE_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ppdm_pkg::CFG_TIMER_WRAP: timer_wrap_r <= cfg_data[ppdm_pkg::TIMER_WRAP_W-1:0];
          ppdm_pkg::CFG_REF_RATE:   ref_rate_r   <= cfg_data;
          default: ;
        endcase
      end

      if (accept && in_data.op == ppdm_pkg::OP_ARM) begin
        armed_r <= 1'b1;
        phase_r <= ppdm_pkg::PH_RISE1;
      end else if (accept && in_data.op == ppdm_pkg::OP_WRAP) begin
        overflow_r <= overflow_r + COUNT_WIDTH'(1);
      end else if (take_first) begin
        phase_r <= ppdm_pkg::PH_FALL;
      end else if (take_second) begin
        phase_r <= ppdm_pkg::PH_RISE2;
      end else if (start_meas) begin
        armed_r <= 1'b0;
        phase_r <= ppdm_pkg::PH_RISE1;
      end

      if (state_r == ppdm_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (take_first) begin
      cap1_r   <= in_data.capture_value;
      stamp1_r <= overflow_r;
    end
    if (take_second) begin
      cap2_r   <= in_data.capture_value;
      stamp2_r <= overflow_r;
    end
    if (start_meas) begin
      cap3_r  <= in_data.capture_value;
      dper_r  <= dper_ext[31:0];
      dhigh_r <= dhigh_ext[31:0];
    end

    unique case (state_r)
      ppdm_pkg::ST_MUL_PER: begin
        prod_r <= mul_p;
      end
      ppdm_pkg::ST_MUL_HIGH: begin
        period_r <= prod_r[31:0] + {16'd0, cap3_r} - {16'd0, cap1_r};
        prod_r   <= mul_p;
      end
      ppdm_pkg::ST_SUM_HIGH: begin
        high_r <= prod_r[31:0] + {16'd0, cap2_r} - {16'd0, cap1_r};
      end
      ppdm_pkg::ST_MUL_DUTY: begin
        prod_r <= mul_p;
        rem_r  <= '0;
        quo_r  <= {ref_rate_r, 16'd0};
        cnt_r  <= '0;
      end
      ppdm_pkg::ST_DIV_FREQ, ppdm_pkg::ST_DIV_DUTY: begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        cnt_r <= cnt_r + ppdm_pkg::STEP_CNT_W'(1);
      end
      ppdm_pkg::ST_LOAD_DUTY: begin
        freq_r <= quo_r[31:0];
        rem_r  <= '0;
        quo_r  <= prod_r[DW-1:0];
        cnt_r  <= '0;
      end
      ppdm_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_r.period_ticks    <= period_r;
          out_data_r.high_ticks      <= high_r;
          out_data_r.freq_hz         <= period_zero ? 32'd0 : freq_r;
          out_data_r.duty_hundredths <= period_zero ? 32'd0 : duty_sat;
          out_data_r.zero_period     <= period_zero;
        end
      end
      default: ;
    endcase
  end

  a_start_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    start_meas |=> (state_r == ppdm_pkg::ST_MUL_PER && !armed_r))
    else $error("measurement start did not launch the sequencer and disarm");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ppdm_pkg::ST_DONE)
    else $error("result appeared without a finished measurement");

  a_zero_quotients: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.zero_period) |->
      (out_data_r.freq_hz == 32'd0 && out_data_r.duty_hundredths == 32'd0))
    else $error("zero period result carries nonzero quotients");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppdm_pkg::ST_DIV_FREQ || state_r == ppdm_pkg::ST_DIV_DUTY) |->
      rem_r < period_r)
    else $error("divider remainder reached the period");

endmodule

// ----- sim/ppdm_measure_check.sv -----
`timescale 1ns / 100ps
module ppdm_measure_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  ppdm_pkg::in_item_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  ppdm_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ppdm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppdm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               outstanding,
  output int                               requests_seen,
  output int                               measurements_checked,
  output int                               zero_periods_seen,
  output int                               saturated_duties_seen
);
  import ppdm_pkg::*;

  logic [TIMER_WRAP_W-1:0] cfg_wrap;
  logic [RATE_W-1:0]       cfg_rate;

  logic        meter_armed;
  phase_t      edge_phase;
  logic [31:0] wrap_count;
  logic [15:0] rise_cap;
  logic [31:0] rise_stamp;
  logic [15:0] fall_cap;
  logic [31:0] fall_stamp;

  out_item_t pending_measurements[$];

  int fail_total = 0;
  int reports = 0;
  int request_total = 0;
  int checked_total = 0;
  int zero_total = 0;
  int sat_total = 0;
  int queued = 0;

  assign fail_count            = fail_total;
  assign outstanding           = queued;
  assign requests_seen         = request_total;
  assign measurements_checked  = checked_total;
  assign zero_periods_seen     = zero_total;
  assign saturated_duties_seen = sat_total;

  // Ticks between two captures: whole timer laps plus the difference of the counts.
  function automatic logic [31:0] tick_span(input logic [31:0] stamp_to,
                                            input logic [15:0] cap_to,
                                            input logic [31:0] stamp_from,
                                            input logic [15:0] cap_from,
                                            input logic [16:0] wrap);
    logic [31:0] laps;
    logic [63:0] prod;
    laps = stamp_to - stamp_from;
    prod = {32'd0, laps} * {47'd0, wrap};
    return prod[31:0] + {16'd0, cap_to} - {16'd0, cap_from};
  endfunction

  task automatic reset_meter();
    cfg_wrap    = TIMER_WRAP_RESET;
    cfg_rate    = REF_RATE_RESET;
    meter_armed = 1'b0;
    edge_phase  = PH_RISE1;
    wrap_count  = '0;
    rise_cap    = '0;
    rise_stamp  = '0;
    fall_cap    = '0;
    fall_stamp  = '0;
  endtask

  task automatic write_setting(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_TIMER_WRAP: cfg_wrap = data[TIMER_WRAP_W-1:0];
      CFG_REF_RATE:   cfg_rate = data;
      default: ;
    endcase
  endtask

  task automatic finish_measurement(input logic [15:0] cap);
    out_item_t   m;
    logic [63:0] ratio;
    m.period_ticks = tick_span(wrap_count, cap, rise_stamp, rise_cap, cfg_wrap);
    m.high_ticks   = tick_span(fall_stamp, fall_cap, rise_stamp, rise_cap, cfg_wrap);
    if (m.period_ticks == 32'd0) begin
      m.freq_hz         = '0;
      m.duty_hundredths = '0;
      m.zero_period     = 1'b1;
    end else begin
      m.freq_hz     = cfg_rate / m.period_ticks;
      ratio         = ({32'd0, m.high_ticks} * 64'd10000) / {32'd0, m.period_ticks};
      m.zero_period = 1'b0;
      // A high time far beyond the period cannot be expressed in 32 bits.
      m.duty_hundredths = (ratio > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : ratio[31:0];
    end
    pending_measurements.push_back(m);
    meter_armed = 1'b0;
    edge_phase  = PH_RISE1;
  endtask

  task automatic advance_meter(input in_item_t req);
    case (req.op)
      OP_ARM: begin
        meter_armed = 1'b1;
        edge_phase  = PH_RISE1;
      end
      OP_WRAP: wrap_count = wrap_count + 32'd1;
      OP_EDGE: begin
        if (meter_armed) begin
          case (edge_phase)
            PH_FALL: begin
              if (!req.edge_rising) begin
                fall_cap   = req.capture_value;
                fall_stamp = wrap_count;
                edge_phase = PH_RISE2;
              end
            end
            PH_RISE2: begin
              if (req.edge_rising) finish_measurement(req.capture_value);
            end
            default: begin
              if (req.edge_rising) begin
                rise_cap   = req.capture_value;
                rise_stamp = wrap_count;
                edge_phase = PH_FALL;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_measurement(input out_item_t got);
    out_item_t want;
    if (pending_measurements.size() == 0) begin
      fail_total++;
      if (reports < 10)
        $display("Unexpected measurement: period %0d high %0d freq %0d duty %0d zero %0b",
                 got.period_ticks, got.high_ticks, got.freq_hz, got.duty_hundredths,
                 got.zero_period);
      reports++;
    end else begin
      want = pending_measurements.pop_front();
      checked_total++;
      if (want.zero_period) zero_total++;
      else if (want.duty_hundredths == 32'hFFFF_FFFF) sat_total++;
      if (got.period_ticks !== want.period_ticks || got.high_ticks !== want.high_ticks ||
          got.freq_hz !== want.freq_hz || got.duty_hundredths !== want.duty_hundredths ||
          got.zero_period !== want.zero_period) begin
        fail_total++;
        if (reports < 10) begin
          $display("Measurement %0d mismatch, expected: period %0d high %0d freq %0d duty %0d zero %0b",
                   checked_total, want.period_ticks, want.high_ticks, want.freq_hz,
                   want.duty_hundredths, want.zero_period);
          $display("  actual: period %0d high %0d freq %0d duty %0d zero %0b",
                   got.period_ticks, got.high_ticks, got.freq_hz, got.duty_hundredths,
                   got.zero_period);
        end
        reports++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_meter();
      pending_measurements.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        request_total++;
        advance_meter(in_data);
      end
      if (out_valid && !out_stall) compare_measurement(out_data);
    end
    queued <= pending_measurements.size();
  end

endmodule

// ----- sim/tb_pulse_period_duty_meter.sv -----
`timescale 1ns / 100ps
module tb_pulse_period_duty_meter;
  import ppdm_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int TIMEOUT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_REQUESTS  = 232;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int outstanding;
  int requests_seen;
  int measurements_checked;
  int zero_periods_seen;
  int saturated_duties_seen;

  int idle_pct = 0;
  int stall_pct = 0;
  int counted_requests = 0;
  bit hold_off_go = 1'b0;
  bit hold_off_done = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  pulse_period_duty_meter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ppdm_measure_check u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data               (in_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_data              (out_data),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .outstanding           (outstanding),
    .requests_seen         (requests_seen),
    .measurements_checked  (measurements_checked),
    .zero_periods_seen     (zero_periods_seen),
    .saturated_duties_seen (saturated_duties_seen)
  );

  function automatic logic [15:0] rand16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic rand_bit();
    logic [31:0] r;
    r = $urandom;
    return r[0];
  endfunction

  function automatic in_item_t make_req(input logic [1:0] op, input logic rising,
                                        input logic [15:0] cap);
    in_item_t item;
    item.op            = op;
    item.edge_rising   = rising;
    item.capture_value = cap;
    return item;
  endfunction

  // Result side: random stalls, plus one long hold-off while requests keep coming.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_request(input in_item_t item, input bit counted);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) counted_requests++;
  endtask

  task automatic send_wraps(input int n);
    repeat (n) send_request(make_req(OP_WRAP, rand_bit(), rand16()), 1'b1);
  endtask

  function automatic int pick_wraps();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(1);
    if (r < 90) return $urandom_range(4, 2);
    return $urandom_range(40, 5);
  endfunction

  // Mostly a full rise, fall, rise sequence; some carry ignored edges, a re-arm or no end.
  task automatic random_measurement();
    logic [15:0] first_cap;
    bit          flat;
    flat = ($urandom_range(99) < 8);
    send_request(make_req(OP_ARM, rand_bit(), rand16()), 1'b1);
    if (!flat) send_wraps(pick_wraps());
    if ($urandom_range(99) < 15) send_request(make_req(OP_EDGE, 1'b0, rand16()), 1'b0);
    first_cap = rand16();
    send_request(make_req(OP_EDGE, 1'b1, first_cap), 1'b1);
    if ($urandom_range(99) < 5) begin
      send_request(make_req(OP_ARM, rand_bit(), rand16()), 1'b1);
      first_cap = rand16();
      send_request(make_req(OP_EDGE, 1'b1, first_cap), 1'b1);
    end
    if (!flat) send_wraps(pick_wraps());
    if ($urandom_range(99) < 10) send_request(make_req(OP_EDGE, 1'b1, rand16()), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, rand16()), 1'b1);
    if (!flat) send_wraps(pick_wraps());
    if ($urandom_range(99) < 10) send_request(make_req(OP_EDGE, 1'b0, rand16()), 1'b0);
    if ($urandom_range(99) >= 4)
      send_request(make_req(OP_EDGE, 1'b1, flat ? first_cap : rand16()), 1'b1);
  endtask

  task automatic random_noise();
    logic [1:0] op;
    repeat ($urandom_range(4, 1)) begin
      op = 2'($urandom_range(3));
      send_request(make_req(op, rand_bit(), rand16()), op == OP_ARM || op == OP_WRAP);
    end
  endtask

  // Wait until every expected measurement has been delivered, then let the block go idle.
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [31:0] wrap_data, input logic [31:0] rate_data);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMER_WRAP;
    cfg_data  <= wrap_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_REF_RATE;
    cfg_data  <= rate_data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [31:0] wrap_data,
                           input logic [31:0] rate_data, input bit with_hold_off);
    settle();
    write_settings(wrap_data, rate_data);
    idle_pct  = idle;
    stall_pct = stall;
    if (with_hold_off) hold_off_go = 1'b1;
    counted_requests = 0;
    while (counted_requests < PHASE_REQUESTS) begin
      if ($urandom_range(99) < 80) random_measurement();
      else random_noise();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edges before arming and an unused opcode are ignored.
    send_request(make_req(OP_EDGE, 1'b1, 16'hFFFF), 1'b0);
    send_request(make_req(OP_UNUSED, 1'b1, 16'hFFFF), 1'b0);
    // Full measurement spanning timer laps, with a wrong-polarity edge in each phase.
    send_request(make_req(OP_ARM, 1'b0, 16'h0000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, 16'd5), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'h0000), 1'b0);
    send_request(make_req(OP_WRAP, 1'b0, 16'h0000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd7), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, 16'hFFFF), 1'b0);
    send_request(make_req(OP_WRAP, 1'b1, 16'hFFFF), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, 16'd3), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'hFFFF), 1'b0);
    // Zero period.
    send_request(make_req(OP_ARM, 1'b1, 16'h0000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd1234), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, 16'd1234), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd1234), 1'b0);
    // A falling count below the rising one makes the high time huge: duty saturates.
    send_request(make_req(OP_ARM, 1'b0, 16'h0000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd1000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, 16'd0), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd1001), 1'b0);
    // Arming again mid-measurement restarts it.
    send_request(make_req(OP_ARM, 1'b0, 16'h0000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd10), 1'b0);
    send_request(make_req(OP_ARM, 1'b0, 16'h0000), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd20), 1'b0);
    send_request(make_req(OP_EDGE, 1'b0, 16'd30), 1'b0);
    send_request(make_req(OP_EDGE, 1'b1, 16'd40), 1'b0);

    run_phase(0, 0, 32'd65536, 32'hFFFF_FFFF, 1'b1);
    run_phase(72, 0, 32'd0, 32'd1, 1'b0);
    run_phase(0, 72, 32'hFFFF_FFFF, $urandom, 1'b0);
    run_phase(10, 10, 32'd1, $urandom, 1'b0);
    settle();

    $display("Covered %0d requests under five register settings and four handshake mixes,",
             requests_seen);
    $display("with one long result hold-off; %0d measurements checked %s",
             measurements_checked, "(zero period and saturated duty counted below).");
    $display("  %0d zero period, %0d saturated duty.", zero_periods_seen,
             saturated_duties_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      if (outstanding != 0) $display("%0d expected measurements never arrived", outstanding);
      $display("%0d failures", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout with %0d measurements outstanding", outstanding);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- pulse_period_duty_meter.f -----
rtl/core/ppdm_pkg.sv
rtl/core/pulse_period_duty_meter.sv
sim/ppdm_measure_check.sv
sim/tb_pulse_period_duty_meter.sv
